@@ rtl/core/fpid_pkg.sv @@
`timescale 1ns / 1ps
// fpid_pkg: shared widths, register indexes and structs for the filtered pid
// depends on nothing; used by the interfaces, the config block, datapath and top level
package fpid_pkg;

	localparam int COEF_W = 32;
	localparam int ERR_W  = 16;
	localparam int OUT_W  = 32;
	localparam int LIM_W  = 31;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;
	// two 64-bit and three 48-bit products summed, with growth bits to spare
	localparam int ACC_W  = 68;

	// command codes of an input request
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_ERR_NOW   = 3'd0,
		REG_ERR_PREV1 = 3'd1,
		REG_ERR_PREV2 = 3'd2,
		REG_OUT_PREV1 = 3'd3,
		REG_OUT_PREV2 = 3'd4,
		REG_OUT_LIMIT = 3'd5
	} cfg_reg_t;

	// coefficient set and clamp limit
	typedef struct packed {
		logic signed [COEF_W-1:0] err_now;
		logic signed [COEF_W-1:0] err_prev1;
		logic signed [COEF_W-1:0] err_prev2;
		logic signed [COEF_W-1:0] out_prev1;
		logic signed [COEF_W-1:0] out_prev2;
		logic        [LIM_W-1:0]  limit;
	} coef_t;

	// filter history
	typedef struct packed {
		logic signed [OUT_W-1:0] out1;
		logic signed [OUT_W-1:0] out2;
		logic signed [ERR_W-1:0] err1;
		logic signed [ERR_W-1:0] err2;
	} hist_t;

endpackage

@@ rtl/core/fpid_in_if.sv @@
`timescale 1ns / 1ps
// fpid_in_if: input request channel carrying command and error sample
// depends on fpid_pkg
interface fpid_in_if import fpid_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic signed [ERR_W-1:0] error_in;

	modport source (output valid, output cmd, output error_in, input ready);
	modport sink (input valid, input cmd, input error_in, output ready);
endinterface

@@ rtl/core/fpid_out_if.sv @@
`timescale 1ns / 1ps
// fpid_out_if: result request channel carrying the clamped control value
// depends on fpid_pkg
interface fpid_out_if import fpid_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] control_out;

	modport source (output valid, output control_out, input ready);
	modport sink (input valid, input control_out, output ready);
endinterface

@@ rtl/core/fpid_cfg.sv @@
`timescale 1ns / 1ps
// fpid_cfg: write-only register file for the five coefficients and the clamp limit
// depends on fpid_pkg
module fpid_cfg import fpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output coef_t             coef
);

	coef_t coef_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.err_now   <= '0;
			coef_q.err_prev1 <= '0;
			coef_q.err_prev2 <= '0;
			coef_q.out_prev1 <= '0;
			coef_q.out_prev2 <= '0;
			coef_q.limit     <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ERR_NOW:   coef_q.err_now   <= cfg_data[COEF_W-1:0];
				REG_ERR_PREV1: coef_q.err_prev1 <= cfg_data[COEF_W-1:0];
				REG_ERR_PREV2: coef_q.err_prev2 <= cfg_data[COEF_W-1:0];
				REG_OUT_PREV1: coef_q.out_prev1 <= cfg_data[COEF_W-1:0];
				REG_OUT_PREV2: coef_q.out_prev2 <= cfg_data[COEF_W-1:0];
				REG_OUT_LIMIT: coef_q.limit     <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

@@ rtl/core/fpid_dp.sv @@
`timescale 1ns / 1ps
// fpid_dp: five parallel products, full-precision sum, fraction shift and clamp
// depends on fpid_pkg
module fpid_dp import fpid_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  coef_t                   coef,
	input  hist_t                   hist,
	input  logic signed [ERR_W-1:0] err,
	output logic signed [OUT_W-1:0] control
);

	logic signed [2*COEF_W-1:0]       p_out1;
	logic signed [2*COEF_W-1:0]       p_out2;
	logic signed [COEF_W+ERR_W-1:0]   p_err0;
	logic signed [COEF_W+ERR_W-1:0]   p_err1;
	logic signed [COEF_W+ERR_W-1:0]   p_err2;
	logic signed [ACC_W-1:0]          acc;
	logic signed [ACC_W-1:0]          shifted;
	logic signed [ACC_W-1:0]          lim_pos;
	logic signed [ACC_W-1:0]          lim_neg;
	logic signed [ACC_W-1:0]          clamped;

	// products of weights and history
	assign p_out1 = $signed(coef.out_prev1) * $signed(hist.out1);
	assign p_out2 = $signed(coef.out_prev2) * $signed(hist.out2);
	assign p_err0 = $signed(coef.err_now) * $signed(err);
	assign p_err1 = $signed(coef.err_prev1) * $signed(hist.err1);
	assign p_err2 = $signed(coef.err_prev2) * $signed(hist.err2);

	// exact sum, then floor shift of the fraction
	assign acc = ACC_W'(p_out1) + ACC_W'(p_out2) + ACC_W'(p_err0)
		+ ACC_W'(p_err1) + ACC_W'(p_err2);
	assign shifted = acc >>> FRAC_BITS;

	// symmetric clamp
	assign lim_pos = $signed({{(ACC_W-LIM_W){1'b0}}, coef.limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		priority if (shifted > lim_pos) begin
			clamped = lim_pos;
		end else if (shifted < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = shifted;
		end
	end

	assign control = clamped[OUT_W-1:0];

endmodule

@@ rtl/core/filtered_pid_with_clamp.sv @@
`timescale 1ns / 1ps
// filtered_pid_with_clamp: second-order iir pid section with output clamp
// a sample request passes the input register, then the result register; a held result can stall it between
// throughput: one request per cycle; a held result stalls a sample, never a flush
// flush requests clear the history and give no result
// reset clears coefficients to zero, the limit to full scale and all history to zero
// depends on fpid_pkg, fpid_in_if, fpid_out_if, fpid_cfg, fpid_dp
module filtered_pid_with_clamp import fpid_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	fpid_in_if.sink           sample,
	fpid_out_if.source        result
);

	coef_t                   coef;
	hist_t                   hist_q;
	logic                    valid_s1;
	logic                    cmd_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic                    adv_s1;
	logic signed [OUT_W-1:0] control;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_data_q;

	fpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	fpid_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.coef    (coef),
		.hist    (hist_q),
		.err     (err_s1),
		.control (control)
	);

	// the compute stage moves on when its result has a free slot or it is a flush
	assign adv_s1 = valid_s1 && ((cmd_s1 == CMD_FLUSH) || !out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			cmd_s1 <= sample.cmd;
			err_s1 <= sample.error_in;
		end
	end

	// filter history, updated as each request leaves the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (adv_s1) begin
			if (cmd_s1 == CMD_FLUSH) begin
				hist_q <= '0;
			end else begin
				hist_q.out2 <= hist_q.out1;
				hist_q.out1 <= control;
				hist_q.err2 <= hist_q.err1;
				hist_q.err1 <= err_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && (cmd_s1 == CMD_SAMPLE)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (cmd_s1 == CMD_SAMPLE)) begin
			out_data_q <= control;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.control_out = out_data_q;

endmodule

@@ sim/filtered_pid_with_clamp_test.sv @@
`timescale 1ns / 1ps
// filtered_pid_with_clamp_test: self-checking bench for the filtered pid with output clamp
// predicts every clamped drive from a private copy of coefficients and history
// depends on fpid_pkg, fpid_in_if, fpid_out_if and the filtered_pid_with_clamp rtl
module filtered_pid_with_clamp_test;
	import fpid_pkg::*;

	localparam int FRAC           = 16;
	localparam int CLK_HALF       = 5;
	localparam int DRAIN_CYCLES   = 4;
	localparam int STALL_LIMIT    = 500;
	localparam int PHASES         = 10;
	localparam int PHASE_REQUESTS = 120;
	localparam int SHOW_MAX       = 10;
	localparam int SUM_W          = 128;
	// register indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam logic [ERR_W-1:0] ERR_MAX     = 16'h7FFF;
	localparam logic [ERR_W-1:0] ERR_MIN     = 16'h8000;

	// private copy of the filter and the drives it still owes
	class drive_ledger;
		coef_t weights;
		hist_t past;
		logic signed [OUT_W-1:0] pending_drive[$];
		int failures;
		int samples;
		int flushes;
		int writes;

		function new();
			weights = '0;
			weights.limit = '1;
			past = '0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			writes++;
			case (idx)
				REG_ERR_NOW:   weights.err_now = data;
				REG_ERR_PREV1: weights.err_prev1 = data;
				REG_ERR_PREV2: weights.err_prev2 = data;
				REG_OUT_PREV1: weights.out_prev1 = data;
				REG_OUT_PREV2: weights.out_prev2 = data;
				REG_OUT_LIMIT: weights.limit = data[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		// full precision sum, floor shift, symmetric clamp, history update
		function logic signed [OUT_W-1:0] next_drive(logic signed [ERR_W-1:0] e);
			longint terms[5];
			logic signed [SUM_W-1:0] total;
			logic signed [SUM_W-1:0] scaled;
			logic signed [SUM_W-1:0] lim_pos;
			logic signed [SUM_W-1:0] lim_neg;
			logic signed [OUT_W-1:0] u;
			terms[0] = longint'(weights.out_prev1) * longint'(past.out1);
			terms[1] = longint'(weights.out_prev2) * longint'(past.out2);
			terms[2] = longint'(weights.err_now) * longint'(e);
			terms[3] = longint'(weights.err_prev1) * longint'(past.err1);
			terms[4] = longint'(weights.err_prev2) * longint'(past.err2);
			total = '0;
			foreach (terms[i])
				total += terms[i];
			scaled = total >>> FRAC;
			lim_pos = $signed({{(SUM_W-LIM_W){1'b0}}, weights.limit});
			lim_neg = -lim_pos;
			if (scaled > lim_pos) begin
				u = lim_pos[OUT_W-1:0];
			end else if (scaled < lim_neg) begin
				u = lim_neg[OUT_W-1:0];
			end else begin
				u = scaled[OUT_W-1:0];
			end
			past.out2 = past.out1;
			past.out1 = u;
			past.err2 = past.err1;
			past.err1 = e;
			return u;
		endfunction

		function void take_sample(logic cmd_v, logic signed [ERR_W-1:0] err_v);
			if (cmd_v == CMD_FLUSH) begin
				past = '0;
				flushes++;
			end else begin
				pending_drive.push_back(next_drive(err_v));
				samples++;
			end
		endfunction

		function void match_drive(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (pending_drive.size() == 0) begin
				failures++;
				if (failures <= SHOW_MAX)
					$display("drive %0d arrived with none outstanding", got);
				return;
			end
			want = pending_drive.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= SHOW_MAX)
					$display("drive mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	int in_gap_max;
	int out_gap_max;

	fpid_in_if in_ch();
	fpid_out_if out_ch();
	drive_ledger ledger = new();

	filtered_pid_with_clamp #(.FRAC_BITS(FRAC)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (in_ch),
		.result    (out_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// result side: random stall before each request, then check it
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			ledger.match_drive(out_ch.control_out);
		end
	end

	// watchdog on cycles with no request moving on either channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// one input request after a random gap
	task automatic send_request(input logic cmd_v, input logic [ERR_W-1:0] err_v);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd_v;
		in_ch.error_in <= err_v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		ledger.take_sample(cmd_v, err_v);
	endtask

	// hold input until every drive is back, then let a trailing flush finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (ledger.pending_drive.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all registers while idle, plus ignored writes to spare indexes
	task automatic load_settings(input logic [DATA_W-1:0] a, b, c, f, g, lim);
		logic [IDX_W-1:0] idx_list[8];
		logic [DATA_W-1:0] val_list[8];
		idx_list = '{REG_SPARE_A, REG_ERR_NOW, REG_ERR_PREV1, REG_ERR_PREV2,
			REG_OUT_PREV1, REG_OUT_PREV2, REG_OUT_LIMIT, REG_SPARE_B};
		val_list = '{$urandom, a, b, c, f, g, lim, $urandom};
		settle();
		cfg_we <= 1'b1;
		foreach (idx_list[i]) begin
			cfg_index <= idx_list[i];
			cfg_data <= val_list[i];
			@(posedge clk);
			ledger.write_reg(idx_list[i], val_list[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// coefficient draw: realistic pid, small, full range or extreme
	function automatic logic [DATA_W-1:0] pick_coef(int kind, int role);
		logic [DATA_W-1:0] v;
		case (kind)
			0: begin
				case (role)
					0: v = $urandom_range(0, 1 << 19);
					1: v = -$urandom_range(0, 1 << 20);
					2: v = $urandom_range(0, 1 << 18);
					3: v = $urandom_range(0, 1 << 16);
					default: v = -$urandom_range(0, 1 << 15);
				endcase
			end
			1: v = $urandom_range(0, 1 << 19) - (1 << 18);
			2: v = $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0001_0000;
					default: v = '0;
				endcase
			end
		endcase
		return v;
	endfunction

	// stimulus
	initial begin
		logic [DATA_W-1:0] lim;
		logic [ERR_W-1:0] err;
		in_gap_max = 11;
		out_gap_max = 11;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= CMD_SAMPLE;
		in_ch.error_in <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weights are zero, so extremes give zero drive
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);

		// moderate pid, flush in the middle of live history
		load_settings(32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000,
			32'h0000_8000, 32'hFFFF_C000, 32'h7FFF_FFFF);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);
		send_request(CMD_SAMPLE, 16'h0000);
		send_request(CMD_SAMPLE, 16'hFFFF);
		send_request(CMD_FLUSH, 16'h1234);
		send_request(CMD_SAMPLE, 16'h0001);
		send_request(CMD_SAMPLE, ERR_MAX);

		// extreme weights drive huge sums into saturation of both signs
		load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);

		// top data bit is dropped from the limit, leaving a zero limit
		load_settings(32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000,
			32'h0000_8000, 32'hFFFF_C000, 32'h8000_0000);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_SAMPLE, ERR_MIN);
		send_request(CMD_SAMPLE, 16'h0100);
		send_request(CMD_SAMPLE, ERR_MAX);

		// integrator against a small limit
		load_settings(32'h0010_0000, '0, '0, 32'h0001_0000, '0, 32'd1000);
		send_request(CMD_SAMPLE, 16'd100);
		send_request(CMD_SAMPLE, 16'd100);
		send_request(CMD_SAMPLE, ERR_MIN);
		send_request(CMD_SAMPLE, ERR_MAX);
		send_request(CMD_FLUSH, ERR_MIN);

		// random phases, each with its own settings and idling pattern
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: lim = '0;
				1: lim = 32'd1;
				2: lim = $urandom_range(1, 65535);
				3: lim = {1'b0, 31'($urandom)};
				4: lim = 32'h7FFF_FFFF;
				default: lim = $urandom;
			endcase
			load_settings(pick_coef(p % 4, 0), pick_coef(p % 4, 1), pick_coef(p % 4, 2),
				pick_coef(p % 4, 3), pick_coef(p % 4, 4), lim);
			in_gap_max = (p % 3 == 0) ? 0 : 11;
			out_gap_max = (p % 2 == 0) ? 0 : 11;
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				// now and then starve the block until it has caught up
				if ($urandom_range(0, 99) == 0)
					settle();
				if ($urandom_range(0, 24) == 0) begin
					send_request(CMD_FLUSH, ERR_W'($urandom));
				end else begin
					case ($urandom_range(0, 9))
						0: err = ERR_MAX;
						1: err = ERR_MIN;
						2: err = ERR_W'($urandom_range(0, 32)) - 16'd16;
						default: err = ERR_W'($urandom);
					endcase
					send_request(CMD_SAMPLE, err);
				end
			end
		end

		settle();
		$display("checked %0d samples and %0d flushes against predicted drives",
			ledger.samples, ledger.flushes);
		$display("%0d register writes over %0d settings, zero and full-scale limits included",
			ledger.writes, PHASES + 4);
		if (ledger.failures == 0 && ledger.pending_drive.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d failures, %0d drives never arrived", ledger.failures,
				ledger.pending_drive.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
